// File: rtl/core/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// Types, codes and helpers for the three-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    FN_APPEND  = 2'd0,
    FN_POP     = 2'd1,
    FN_REMOVE  = 2'd2,
    FN_REORDER = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    COL_RED    = 2'd0,
    COL_YELLOW = 2'd1,
    COL_GREEN  = 2'd2,
    COL_OTHER  = 2'd3
  } color_t;

  typedef struct packed {
    logic [7:0]  kind;
    logic [31:0] id;
    color_t      color;
  } entry_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/three_class_priority_queue.sv
// append and the empty-store cases: the input beat goes from S_IDLE straight to S_FIN
// pop and remove: one stored entry read per cycle, walked up to the occupancy
// reorder: three passes over the store through the one memory read port;
// one input beat is in work at a time
// rst clears the occupancy, the colour counts and the handshake state;
// the entry memory is not cleared and is only read below the occupancy
// ----------------------------------------------------------------------------
// three_class_priority_queue
// Ordered entry store with append, pop, remove by id and a stable
// red / yellow / rest partition, walked through one memory port.
// ----------------------------------------------------------------------------
module three_class_priority_queue
  import tcpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // func, kind, entry_id, color, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // status, out_kind, out_id, out_color,
                                 // red_count, yellow_count, green_count, occupancy
);

  localparam logic [1:0] PASS_LAST = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_PART = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;

  // two banks: reorder copies from one into the other, then swaps
  entry_t mem [2*DEPTH];
  entry_t rdata;
  logic   [IDX_W:0] raddr;
  logic   [IDX_W:0] waddr;
  entry_t wdata;
  logic   we;

  logic bank;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] red_cnt;
  logic [CNT_W-1:0] yellow_cnt;
  logic [CNT_W-1:0] green_cnt;

  logic             iss_on;
  logic [IDX_W-1:0] iss_idx;
  logic [1:0]       iss_pass;
  logic             iss_last;
  logic [IDX_W-1:0] last_idx;

  logic             p_v;
  logic [IDX_W-1:0] p_idx;
  logic [1:0]       p_pass;
  logic             p_last;

  logic        is_pop;
  logic        found;
  logic [31:0] key;
  logic [IDX_W-1:0] wr_n;

  status_t     res_status;
  logic [7:0]  res_kind;
  logic [31:0] res_id;
  color_t      res_color;

  func_t  in_func;
  entry_t in_entry;
  logic   accept;
  logic   match;
  logic   found_now;
  color_t rm_color;
  logic   take;

  assign in_func        = func_t'(s_tdata[1:0]);
  assign in_entry.kind  = to_lower(s_tdata[9:2]);
  assign in_entry.id    = s_tdata[41:10];
  assign in_entry.color = color_t'(s_tdata[43:42]);

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign iss_last = (iss_idx == last_idx) && ((state == S_WALK) || (iss_pass == PASS_LAST));
  assign raddr    = {bank, iss_idx};

  assign match     = is_pop ? (p_idx == '0) : (rdata.id == key);
  assign found_now = found || match;
  assign rm_color  = found ? res_color : rdata.color;

  always_comb begin
    case (p_pass)
      2'd0:    take = (rdata.color == COL_RED);
      2'd1:    take = (rdata.color == COL_YELLOW);
      default: take = rdata.color[1];
    endcase
  end

  // single write port
  always_comb begin
    we    = 1'b0;
    waddr = {bank, count[IDX_W-1:0]};
    wdata = in_entry;
    case (state)
      S_IDLE: begin
        we = accept && (in_func == FN_APPEND) && (count != CNT_W'(DEPTH));
      end
      S_WALK: begin
        // entries behind the removed one close the gap
        we    = p_v && found;
        waddr = {bank, p_idx - IDX_W'(1)};
        wdata = rdata;
      end
      S_PART: begin
        we    = p_v && take;
        waddr = {~bank, wr_n};
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // read issue and the matching pipeline tag
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_on <= 1'b0;
      p_v    <= 1'b0;
    end else begin
      p_v    <= iss_on;
      p_idx  <= iss_idx;
      p_pass <= iss_pass;
      p_last <= iss_last;
      if (accept) begin
        iss_idx  <= '0;
        iss_pass <= '0;
        iss_on   <= (count != '0) && (in_func != FN_APPEND);
      end else if (iss_on) begin
        if (iss_idx == last_idx) begin
          iss_idx <= '0;
          if (iss_last) begin
            iss_on <= 1'b0;
          end else begin
            iss_pass <= iss_pass + 2'd1;
          end
        end else begin
          iss_idx <= iss_idx + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bank       <= 1'b0;
      count      <= '0;
      red_cnt    <= '0;
      yellow_cnt <= '0;
      green_cnt  <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // in S_FIN the beat is reloaded below
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_status <= ST_OK;
            res_kind   <= '0;
            res_id     <= '0;
            res_color  <= COL_RED;
            found      <= 1'b0;
            is_pop     <= (in_func == FN_POP);
            key        <= in_entry.id;
            wr_n       <= '0;
            case (in_func)
              FN_APPEND: begin
                state <= S_FIN;
                if (count == CNT_W'(DEPTH)) begin
                  res_status <= ST_FULL;
                end else begin
                  count <= count + CNT_W'(1);
                  case (in_entry.color)
                    COL_RED:    red_cnt    <= red_cnt + CNT_W'(1);
                    COL_YELLOW: yellow_cnt <= yellow_cnt + CNT_W'(1);
                    COL_GREEN:  green_cnt  <= green_cnt + CNT_W'(1);
                    default:    ;
                  endcase
                end
              end
              FN_POP, FN_REMOVE: begin
                if (count == '0) begin
                  res_status <= ST_MISS;
                  state      <= S_FIN;
                end else begin
                  state <= S_WALK;
                end
              end
              default: begin
                state <= (count == '0) ? S_FIN : S_PART;
              end
            endcase
          end
        end
        S_WALK: begin
          if (p_v) begin
            if (!found && match) begin
              found     <= 1'b1;
              res_kind  <= rdata.kind;
              res_id    <= rdata.id;
              res_color <= rdata.color;
            end
            if (p_last) begin
              state <= S_FIN;
              if (found_now) begin
                count <= count - CNT_W'(1);
                case (rm_color)
                  COL_RED:    red_cnt    <= red_cnt - CNT_W'(1);
                  COL_YELLOW: yellow_cnt <= yellow_cnt - CNT_W'(1);
                  COL_GREEN:  green_cnt  <= green_cnt - CNT_W'(1);
                  default:    ;
                endcase
              end else begin
                res_status <= ST_MISS;
              end
            end
          end
        end
        S_PART: begin
          if (p_v) begin
            if (take) begin
              wr_n <= wr_n + IDX_W'(1);
            end
            if (p_last) begin
              bank  <= ~bank;
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {count[4:0], green_cnt[4:0], yellow_cnt[4:0], red_cnt[4:0],
                         res_color, res_id, res_kind, res_status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sim/tcpq_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcpq_result_checker
// Watches both stream channels of the priority queue, keeps a shadow copy
// of the entry store, works out the result of every accepted input beat and
// compares each output beat against the oldest outstanding one.
// ----------------------------------------------------------------------------
module tcpq_result_checker
  import tcpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  output int          mismatches,
  output int          pending,
  output int          checked,
  output int          full_drops,
  output int          misses
);

  // laid out so that a cast of m_tdata lines up, status in the lowest bits
  typedef struct packed {
    logic [4:0]  occ;
    logic [4:0]  green;
    logic [4:0]  yellow;
    logic [4:0]  red;
    color_t      color;
    logic [31:0] id;
    logic [7:0]  kind;
    status_t     status;
  } queue_result_t;

  logic [7:0]    held_kinds [DEPTH];
  logic [31:0]   held_ids [DEPTH];
  color_t        held_colors [DEPTH];
  int            held_count;
  queue_result_t expected_results [$];

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
    full_drops = 0;
    misses     = 0;
    held_count = 0;
  end

  function automatic string show(queue_result_t r);
    return $sformatf("status=%0d kind=%02h id=%08h color=%0d red=%0d yellow=%0d green=%0d occ=%0d",
                     r.status, r.kind, r.id, r.color, r.red, r.yellow, r.green, r.occ);
  endfunction

  function automatic queue_result_t apply_op(func_t op, logic [7:0] k, logic [31:0] id,
                                             color_t c);
    queue_result_t r;
    logic [7:0]    tk [DEPTH];
    logic [31:0]   tid [DEPTH];
    color_t        tc [DEPTH];
    int            pos;
    int            n;
    r   = '0;
    pos = -1;
    n   = 0;
    case (op)
      FN_APPEND: begin
        if (held_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          held_kinds[held_count]  = (k >= 8'h41 && k <= 8'h5a) ? k + 8'h20 : k;
          held_ids[held_count]    = id;
          held_colors[held_count] = c;
          held_count++;
        end
      end
      FN_POP, FN_REMOVE: begin
        if (op == FN_POP) begin
          if (held_count > 0) pos = 0;
        end else begin
          for (int i = 0; i < held_count && pos < 0; i++) begin
            if (held_ids[i] == id) pos = i;
          end
        end
        if (pos < 0) begin
          r.status = ST_MISS;
        end else begin
          r.kind  = held_kinds[pos];
          r.id    = held_ids[pos];
          r.color = held_colors[pos];
          for (int i = pos; i + 1 < held_count; i++) begin
            held_kinds[i]  = held_kinds[i + 1];
            held_ids[i]    = held_ids[i + 1];
            held_colors[i] = held_colors[i + 1];
          end
          held_count--;
        end
      end
      default: begin
        // stable partition: red, then yellow, then green and other together
        for (int pass = 0; pass < 3; pass++) begin
          for (int i = 0; i < held_count; i++) begin
            if ((pass < 2 && held_colors[i] == color_t'(pass)) ||
                (pass == 2 && held_colors[i] >= COL_GREEN)) begin
              tk[n]  = held_kinds[i];
              tid[n] = held_ids[i];
              tc[n]  = held_colors[i];
              n++;
            end
          end
        end
        for (int i = 0; i < n; i++) begin
          held_kinds[i]  = tk[i];
          held_ids[i]    = tid[i];
          held_colors[i] = tc[i];
        end
      end
    endcase
    for (int i = 0; i < held_count; i++) begin
      case (held_colors[i])
        COL_RED:    r.red++;
        COL_YELLOW: r.yellow++;
        COL_GREEN:  r.green++;
        default:    ;
      endcase
    end
    r.occ = 5'(held_count);
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (rst) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      // an output beat can never belong to the input beat of the same edge
      if (m_tvalid && m_tready) begin
        got = queue_result_t'(m_tdata);
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %s", show(got));
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got.status !== want.status || got.kind !== want.kind || got.id !== want.id ||
              got.color !== want.color || got.red !== want.red ||
              got.yellow !== want.yellow || got.green !== want.green ||
              got.occ !== want.occ) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch on result %0d at %0t", checked, $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = apply_op(func_t'(s_tdata[1:0]), s_tdata[9:2], s_tdata[41:10],
                        color_t'(s_tdata[43:42]));
        if (want.status == ST_FULL) full_drops++;
        if (want.status == ST_MISS) misses++;
        expected_results.push_back(want);
      end
    end
    pending = expected_results.size();
  end

endmodule

// File: sim/three_class_priority_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_class_priority_queue_test
// Drives the priority queue with a directed run over the empty and full
// store, case folding and id extremes, then a long random mix of appends,
// pops, removes and reorders with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module three_class_priority_queue_test;
  import tcpq_pkg::*;

  localparam logic [7:0]  EDGE_KINDS [8] = '{8'h41, 8'h5a, 8'h40, 8'h5b,
                                             8'h00, 8'hff, 8'h61, 8'h7a};
  localparam logic [31:0] EDGE_IDS [6]   = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                             32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa};
  localparam logic [31:0] TWIN_ID        = 32'h1234_5678;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // func, kind, entry_id, color, zero pad
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // status, out_kind, out_id, out_color,
                          // red_count, yellow_count, green_count, occupancy

  int          mismatches;
  int          pending;
  int          checked;
  int          full_drops;
  int          misses;
  int          items_sent = 0;
  int          op_counts [4] = '{0, 0, 0, 0};
  bit          steady = 1'b0;
  logic [31:0] id_pool [8];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  three_class_priority_queue uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  tcpq_result_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .full_drops (full_drops),
    .misses     (misses)
  );

  task automatic offer(input func_t op, input logic [7:0] k, input logic [31:0] id,
                       input color_t c);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 36) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, c, id, k, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    op_counts[op]++;
  endtask

  // result side; one long hold-off lets the queue back up into its input
  initial begin : sink
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && items_sent >= 120) begin
        held      = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= steady || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  initial begin : stimulus
    bit          fill_phase;
    int          roll;
    func_t       op;
    logic [7:0]  k;
    logic [31:0] id;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    fill_phase = 1'b0;
    foreach (id_pool[i]) id_pool[i] = $urandom;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty store
    offer(FN_POP, 8'h00, 32'h0, COL_RED);
    offer(FN_REMOVE, 8'h00, 32'h0, COL_RED);
    offer(FN_REORDER, 8'h00, 32'h0, COL_RED);
    // fill to the brim, with two entries sharing an id
    for (int i = 0; i < DEPTH; i++) begin
      offer(FN_APPEND, (i < 8) ? EDGE_KINDS[i] : 8'(8'h41 + i * 2),
            (i < 6) ? EDGE_IDS[i] : ((i == 10 || i == 12) ? TWIN_ID : 32'(i)),
            color_t'(3 - i % 4));
    end
    offer(FN_APPEND, 8'h5a, 32'h1, COL_RED);
    offer(FN_REORDER, 8'h00, 32'h0, COL_RED);
    offer(FN_REMOVE, 8'h00, TWIN_ID, COL_RED);
    offer(FN_REMOVE, 8'h00, 32'hdead_beef, COL_RED);
    offer(FN_POP, 8'h00, 32'h0, COL_RED);
    offer(FN_REMOVE, 8'h00, 32'h7fff_ffff, COL_RED);

    // random mix, alternating between filling and draining the store
    for (int n = 0; n < 400; n++) begin
      if (n % 50 == 0) fill_phase = !fill_phase;
      steady = (n >= 200 && n < 280);
      roll = $urandom_range(0, 99);
      if (roll < (fill_phase ? 60 : 20)) begin
        op = FN_APPEND;
      end else begin
        roll = $urandom_range(0, 9);
        op = (roll < 4) ? FN_POP : ((roll < 8) ? FN_REMOVE : FN_REORDER);
      end
      k  = ($urandom_range(0, 9) < 3) ? 8'($urandom_range(8'h41, 8'h5a))
                                      : 8'($urandom_range(0, 255));
      id = ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, 7)] : $urandom;
      offer(op, k, id, color_t'($urandom_range(0, 3)));
    end
    steady = 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (60) @(posedge clk);
    $display("%0d beats sent: %0d appends, %0d pops, %0d removes, %0d reorders",
             items_sent, op_counts[FN_APPEND], op_counts[FN_POP],
             op_counts[FN_REMOVE], op_counts[FN_REORDER]);
    $display("%0d results compared, %0d appends dropped when full, %0d misses, %0d mismatches",
             checked, full_drops, misses, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/core/tcpq_pkg.sv
rtl/core/three_class_priority_queue.sv
sim/tcpq_result_checker.sv
sim/three_class_priority_queue_test.sv
